/* rtl/ttf_pkg.sv */
// ttf_pkg: shared types and fixed widths for the triangle tangent frame block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none
package ttf_pkg;

	localparam int MUL_W  = 34;	// shared multiplier operand width
	localparam int PROD_W = 2 * MUL_W;
	localparam int VEC_W  = 60;	// det, tangent and bitangent before normalizing
	localparam int MAG_W  = 30;	// normalized magnitudes, top bit at 29
	localparam int SUM_W  = 62;	// sum of three squares
	localparam int ROOT_W = 31;	// floor square root of SUM_W bits
	localparam int POS_W  = 32;
	localparam int TEX_W  = 24;
	localparam int IDX_W  = 24;
	localparam int OUT_W  = 16;
	localparam int SAT_MAX = 32767;
	localparam logic [3:0] LAST_TAG = 4'd13;
	localparam logic [1:0] LAST_SQ  = 2'd2;
	localparam logic [1:0] LAST_COMP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_WAIT,
		ST_CHECK,
		ST_LOAD,
		ST_SHIFT,
		ST_SQ,
		ST_SQ_WAIT,
		ST_SQRT_GO,
		ST_SQRT,
		ST_DIV,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

/* rtl/ttf_mul.sv */
// ttf_mul: the shared signed multiplier, one registered product per cycle.
// Depends on ttf_pkg for operand widths.
`default_nettype none
module ttf_mul (
	input  wire                               clk,
	input  wire logic signed [ttf_pkg::MUL_W-1:0]  a,
	input  wire logic signed [ttf_pkg::MUL_W-1:0]  b,
	output logic signed [ttf_pkg::PROD_W-1:0]      p_s1
);
	import ttf_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule
`default_nettype wire

/* rtl/ttf_isqrt.sv */
// ttf_isqrt: iterative floor square root, two radicand bits per cycle.
// Depends on ttf_pkg for SUM_W and ROOT_W.
`default_nettype none
module ttf_isqrt (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire logic [ttf_pkg::SUM_W-1:0] radicand,
	output logic                           done,
	output logic [ttf_pkg::ROOT_W-1:0]     root
);
	import ttf_pkg::*;

	logic             busy_q, done_q;
	logic [SUM_W-1:0] n_q, res_q, bit_q;
	logic [SUM_W-1:0] trial;
	logic             ge;

	assign trial = res_q + bit_q;
	assign ge    = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= SUM_W'(1) << (SUM_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

/* rtl/ttf_div.sv */
// ttf_div: restoring divider, one quotient bit per cycle.
// Depends on ttf_pkg for ROOT_W; quotient width set by the instantiating level.
`default_nettype none
module ttf_div #(
	parameter int QW = 16,
	parameter int NW = 46
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire logic [NW-1:0]              num,
	input  wire logic [ttf_pkg::ROOT_W-1:0] den,
	output logic                            done,
	output logic [QW-1:0]                   quot
);
	import ttf_pkg::*;

	localparam int CW = $clog2(QW + 1);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [ROOT_W-1:0] rem_q;
	logic [QW-1:0]     lo_q, quot_q;
	logic [ROOT_W:0]   rem2, diff;
	logic              ge;

	assign rem2 = {rem_q, lo_q[QW-1]};
	assign ge   = rem2 >= {1'b0, den};
	assign diff = rem2 - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(num[NW-1:QW]);
			lo_q  <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q  <= ge ? diff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
			lo_q   <= lo_q << 1;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

/* rtl/triangle_tangent_frame.sv */
// Triangle tangent frame. Corners arrive one transaction each on the corner
// channel (corner_valid / corner_stall); after every third corner the block
// emits three frame transactions (frame_valid / frame_stall), one per corner
// index in arrival order, the third flagged last_of_triangle.
// The first two corners of a triangle are just stored. The third
// starts a sequence on one shared 34x34 multiplier (14 products plus 3 squares
// per vector), a 31-step square root and a divider giving OUT_FRAC_BITS+1
// quotient bits per component. The alignment shift moves one bit per step,
// 0 to 29 bits per vector. A zero determinant, tangent or bitangent ends
// the sequence early and gives degenerate frames.
// corner_stall is high from the third corner until the last frame has been
// taken. Frames hold stable while frame_stall is high; the block waits.
// Reset clears the corner count and the sequencer; held corners need no reset.
// Pipeline: ttf_mul -> accumulator, ttf_isqrt for length, ttf_div per component.
// Depends on ttf_pkg, ttf_mul, ttf_isqrt and ttf_div.
`default_nettype none
module triangle_tangent_frame #(
	parameter int OUT_FRAC_BITS = 15
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               corner_valid,
	output logic              corner_stall,
	input  wire logic [23:0]  vertex_index,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [23:0] tex_u,
	input  wire logic signed [23:0] tex_v,
	output logic              frame_valid,
	input  wire               frame_stall,
	output logic [23:0]       corner_index,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic signed [15:0] bitangent_x,
	output logic signed [15:0] bitangent_y,
	output logic signed [15:0] bitangent_z,
	output logic              degenerate,
	output logic              last_of_triangle
);
	import ttf_pkg::*;

	localparam int QW  = OUT_FRAC_BITS + 1;
	localparam int NW  = MAG_W + OUT_FRAC_BITS + 1;
	localparam int LIM = ((2 ** OUT_FRAC_BITS) - 1 > SAT_MAX) ?
		SAT_MAX : (2 ** OUT_FRAC_BITS) - 1;

	state_t state_q, state_n;

	// held corners
	logic [1:0]                     count_q;
	logic [IDX_W-1:0]               idx_q [3];
	logic signed [POS_W-1:0]        pos_q [2][3];
	logic signed [TEX_W-1:0]        tex_q [2][2];

	logic signed [POS_W:0]          e1_q [3], e2_q [3];
	logic signed [TEX_W:0]          du1_q, dv1_q, du2_q, dv2_q;

	logic [3:0]                     mi_q;
	logic [1:0]                     si_q, ci_q, k_q;
	logic                           vi_q;
	logic                           pv_s1, sq_s1;
	logic [3:0]                     tag_s1;
	logic signed [VEC_W-1:0]        first_q;
	logic signed [VEC_W-1:0]        vec_q [7];
	logic [VEC_W-1:0]               m_q [3];
	logic [2:0]                     sgn_q;
	logic [SUM_W-1:0]               sum_q;
	logic [ROOT_W-1:0]              len_q;
	logic signed [OUT_W-1:0]        res_q [6];
	logic                           degen_q, det_neg_q;

	logic                           accept, emit_take;
	logic                           mul_issue, sq_issue;
	logic                           sqrt_start, sqrt_done;
	logic                           div_start, div_done;
	logic signed [MUL_W-1:0]        op_a, op_b;
	logic signed [PROD_W-1:0]       prod_s1;
	logic [ROOT_W-1:0]              root;
	logic [QW-1:0]                  quot;
	logic [NW-1:0]                  div_num;
	logic [VEC_W-1:0]               or_w;
	logic [VEC_W-1:0]               m_sel;
	logic [3:0]                     mrel;
	logic [1:0]                     comp;
	logic [QW-1:0]                  qc;
	logic [2:0]                     res_idx;

	assign accept    = corner_valid && !corner_stall;
	assign emit_take = frame_valid && !frame_stall;
	assign corner_stall = (state_q != ST_IDLE);
	assign frame_valid  = (state_q == ST_EMIT);

	function automatic logic [VEC_W-1:0] pick_m(input logic [VEC_W-1:0] m0,
		input logic [VEC_W-1:0] m1, input logic [VEC_W-1:0] m2, input logic [1:0] s);
		case (s)
			2'd0:    pick_m = m0;
			2'd1:    pick_m = m1;
			default: pick_m = m2;
		endcase
	endfunction

	function automatic logic signed [POS_W:0] pick_e(input logic signed [POS_W:0] x0,
		input logic signed [POS_W:0] x1, input logic signed [POS_W:0] x2,
		input logic [1:0] s);
		case (s)
			2'd0:    pick_e = x0;
			2'd1:    pick_e = x1;
			default: pick_e = x2;
		endcase
	endfunction

	// operand selection for the shared multiplier
	always_comb begin
		mrel  = (mi_q >= 4'd8) ? mi_q - 4'd8 : mi_q - 4'd2;
		comp  = mrel[2:1];
		m_sel = pick_m(m_q[0], m_q[1], m_q[2], si_q);
		op_a  = '0;
		op_b  = '0;
		if (sq_issue) begin
			op_a = MUL_W'(signed'({1'b0, m_sel[MAG_W-1:0]}));
			op_b = op_a;
		end else if (mi_q == 4'd0) begin
			op_a = MUL_W'(du1_q);
			op_b = MUL_W'(dv2_q);
		end else if (mi_q == 4'd1) begin
			op_a = MUL_W'(du2_q);
			op_b = MUL_W'(dv1_q);
		end else if (mi_q < 4'd8) begin
			op_a = mrel[0] ? MUL_W'(dv1_q) : MUL_W'(dv2_q);
			op_b = mrel[0] ? MUL_W'(pick_e(e2_q[0], e2_q[1], e2_q[2], comp)) :
				MUL_W'(pick_e(e1_q[0], e1_q[1], e1_q[2], comp));
		end else begin
			op_a = mrel[0] ? MUL_W'(du2_q) : MUL_W'(du1_q);
			op_b = mrel[0] ? MUL_W'(pick_e(e1_q[0], e1_q[1], e1_q[2], comp)) :
				MUL_W'(pick_e(e2_q[0], e2_q[1], e2_q[2], comp));
		end
	end

	ttf_mul u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.p_s1 (prod_s1)
	);

	ttf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (root)
	);

	assign div_num = (NW'(pick_m(m_q[0], m_q[1], m_q[2], ci_q)) << OUT_FRAC_BITS)
		+ NW'(len_q >> 1);

	ttf_div #(
		.QW (QW),
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (len_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign or_w    = m_q[0] | m_q[1] | m_q[2];
	assign qc      = (quot > QW'(LIM)) ? QW'(LIM) : quot;
	assign res_idx = vi_q ? 3'(ci_q) + 3'd3 : 3'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		mul_issue  = 1'b0;
		sq_issue   = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE:     if (accept && count_q[1]) state_n = ST_MUL;
			ST_MUL: begin
				mul_issue = 1'b1;
				if (mi_q == LAST_TAG) state_n = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: state_n = ST_CHECK;
			ST_CHECK:    state_n = (vec_q[0] == '0) ? ST_EMIT : ST_LOAD;
			ST_LOAD: begin
				if (vec_q[vi_q ? 4 : 1] == '0 && vec_q[vi_q ? 5 : 2] == '0 &&
					vec_q[vi_q ? 6 : 3] == '0) begin
					state_n = ST_EMIT;
				end else begin
					state_n = ST_SHIFT;
				end
			end
			ST_SHIFT:    if (!(|or_w[VEC_W-1:MAG_W]) && or_w[MAG_W-1]) state_n = ST_SQ;
			ST_SQ: begin
				sq_issue = 1'b1;
				if (si_q == LAST_SQ) state_n = ST_SQ_WAIT;
			end
			ST_SQ_WAIT:  state_n = ST_SQRT_GO;
			ST_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_n    = ST_SQRT;
			end
			ST_SQRT:     if (sqrt_done) state_n = ST_DIV;
			ST_DIV: begin
				div_start = 1'b1;
				state_n   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (ci_q != LAST_COMP) state_n = ST_DIV;
					else if (!vi_q)        state_n = ST_LOAD;
					else                   state_n = ST_EMIT;
				end
			end
			ST_EMIT:     if (emit_take && k_q == 2'd2) state_n = ST_IDLE;
			default:     state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pv_s1   <= 1'b0;
			mi_q    <= '0;
			si_q    <= '0;
			ci_q    <= '0;
			k_q     <= '0;
			vi_q    <= 1'b0;
			degen_q <= 1'b0;
		end else begin
			pv_s1 <= mul_issue || sq_issue;
			if (accept) begin
				count_q <= count_q[1] ? 2'd0 : count_q + 2'd1;
			end
			if (state_q == ST_IDLE) begin
				mi_q    <= '0;
				vi_q    <= 1'b0;
				k_q     <= '0;
				degen_q <= 1'b0;
			end
			if (mul_issue) mi_q <= mi_q + 4'd1;
			if (sq_issue)  si_q <= si_q + 2'd1;
			if (state_q == ST_CHECK && vec_q[0] == '0) degen_q <= 1'b1;
			if (state_q == ST_LOAD) begin
				si_q <= '0;
				ci_q <= '0;
				if (state_n == ST_EMIT) degen_q <= 1'b1;
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				ci_q <= ci_q + 2'd1;
				if (ci_q == LAST_COMP) vi_q <= 1'b1;
			end
			if (emit_take) k_q <= k_q + 2'd1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		tag_s1 <= mi_q;
		sq_s1  <= sq_issue;
		if (accept) begin
			if (!count_q[1]) begin
				idx_q[count_q[0]]    <= vertex_index;
				pos_q[count_q[0]][0] <= pos_x;
				pos_q[count_q[0]][1] <= pos_y;
				pos_q[count_q[0]][2] <= pos_z;
				tex_q[count_q[0]][0] <= tex_u;
				tex_q[count_q[0]][1] <= tex_v;
			end else begin
				idx_q[2] <= vertex_index;
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= (POS_W+1)'(pos_q[1][i]) - (POS_W+1)'(pos_q[0][i]);
				end
				e2_q[0] <= (POS_W+1)'(pos_x) - (POS_W+1)'(pos_q[0][0]);
				e2_q[1] <= (POS_W+1)'(pos_y) - (POS_W+1)'(pos_q[0][1]);
				e2_q[2] <= (POS_W+1)'(pos_z) - (POS_W+1)'(pos_q[0][2]);
				du1_q <= (TEX_W+1)'(tex_q[1][0]) - (TEX_W+1)'(tex_q[0][0]);
				dv1_q <= (TEX_W+1)'(tex_q[1][1]) - (TEX_W+1)'(tex_q[0][1]);
				du2_q <= (TEX_W+1)'(tex_u) - (TEX_W+1)'(tex_q[0][0]);
				dv2_q <= (TEX_W+1)'(tex_v) - (TEX_W+1)'(tex_q[0][1]);
			end
		end
		// pair up products: even tag holds the first term, odd tag subtracts
		if (pv_s1) begin
			if (sq_s1) begin
				sum_q <= sum_q + prod_s1[SUM_W-1:0];
			end else if (!tag_s1[0]) begin
				first_q <= prod_s1[VEC_W-1:0];
			end else begin
				vec_q[tag_s1[3:1]] <= first_q - prod_s1[VEC_W-1:0];
			end
		end
		if (state_q == ST_CHECK) det_neg_q <= vec_q[0][VEC_W-1];
		if (state_q == ST_LOAD) begin
			sum_q <= '0;
			for (int i = 0; i < 3; i++) begin
				m_q[i]   <= vec_q[(vi_q ? 4 : 1) + i][VEC_W-1] ?
					VEC_W'(-vec_q[(vi_q ? 4 : 1) + i]) : vec_q[(vi_q ? 4 : 1) + i];
				sgn_q[i] <= vec_q[(vi_q ? 4 : 1) + i][VEC_W-1] ^ det_neg_q;
			end
		end
		if (state_q == ST_SHIFT) begin
			for (int i = 0; i < 3; i++) begin
				if (|or_w[VEC_W-1:MAG_W]) m_q[i] <= m_q[i] >> 1;
				else if (!or_w[MAG_W-1])  m_q[i] <= m_q[i] << 1;
			end
		end
		if (state_q == ST_SQRT && sqrt_done) len_q <= root;
		if (state_q == ST_DIV_WAIT && div_done) begin
			res_q[res_idx] <= sgn_q[ci_q] ? -OUT_W'(qc) : OUT_W'(qc);
		end
	end

	always_comb begin
		case (k_q)
			2'd0:    corner_index = idx_q[0];
			2'd1:    corner_index = idx_q[1];
			default: corner_index = idx_q[2];
		endcase
	end

	assign tangent_x        = degen_q ? '0 : res_q[0];
	assign tangent_y        = degen_q ? '0 : res_q[1];
	assign tangent_z        = degen_q ? '0 : res_q[2];
	assign bitangent_x      = degen_q ? '0 : res_q[3];
	assign bitangent_y      = degen_q ? '0 : res_q[4];
	assign bitangent_z      = degen_q ? '0 : res_q[5];
	assign degenerate       = degen_q;
	assign last_of_triangle = (k_q == 2'd2);

`ifndef ASSERT_OFF
	a_no_count3: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("corner count reached three");
	a_frame_blocks_corner: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> corner_stall) else $error("corner taken during emit");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_take && last_of_triangle) |=> !frame_valid)
		else $error("frame after last of triangle");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && degenerate) |-> (tangent_x == 0 && bitangent_z == 0))
		else $error("degenerate frame not zeroed");
	a_emit_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> count_q == 2'd0) else $error("count not cleared");
`endif

endmodule
`default_nettype wire
